// File: hdl/assert_macros.svh
// Assertion macros shared by the pixel stream unpacker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define BPSU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BPSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/bpsu_pkg.sv
// Shared types and constants of the BMP pixel stream unpacker.
package bpsu_pkg;

    localparam int unsigned CountWidth = 15;
    localparam int unsigned SizeWidth  = 16;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned CfgDataWidth = 16;
    localparam int unsigned OutDataWidth = 56;

    localparam logic [CfgIdxWidth-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_FOUR_BYTE     = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_COLUMN_OFFSET = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_ROW_OFFSET    = 3'd4;

    typedef enum logic [1:0] {
        PHASE_BLUE     = 2'd0,
        PHASE_GREEN    = 2'd1,
        PHASE_RED      = 2'd2,
        PHASE_RESERVED = 2'd3
    } byte_phase_t;

    // Decoded configuration handed from the register file to the decoder.
    typedef struct packed {
        logic [CountWidth-1:0] width_m1;
        logic [CountWidth-1:0] height_m1;
        logic [1:0]            pad_bytes;
        logic                  four_byte;
        logic [CountWidth-1:0] column_offset;
        logic [CountWidth-1:0] row_offset;
    } bpsu_cfg_t;

endpackage

// File: hdl/bpsu_cfg_regs.sv
// Configuration registers and the clamped image geometry derived from them.
module bpsu_cfg_regs
    import bpsu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_wdata,
    output bpsu_cfg_t               cfg
);

    logic [SizeWidth-1:0]  width_reg;
    logic [SizeWidth-1:0]  height_reg;
    logic                  four_byte_reg;
    logic [CountWidth-1:0] col_off_reg;
    logic [CountWidth-1:0] row_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= SizeWidth'(1);
            height_reg    <= SizeWidth'(1);
            four_byte_reg <= 1'b0;
            col_off_reg   <= '0;
            row_off_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg     <= cfg_wdata;
                CFG_IMAGE_HEIGHT:  height_reg    <= cfg_wdata;
                CFG_FOUR_BYTE:     four_byte_reg <= cfg_wdata[0];
                CFG_COLUMN_OFFSET: col_off_reg   <= cfg_wdata[CountWidth-1:0];
                CFG_ROW_OFFSET:    row_off_reg   <= cfg_wdata[CountWidth-1:0];
                default: ;
            endcase
        end
    end

    // A size of zero acts as one, anything above 32768 acts as 32768.
    always_comb begin
        if (width_reg[SizeWidth-1]) begin
            cfg.width_m1  = '1;
            cfg.pad_bytes = 2'd0;
        end else if (width_reg == '0) begin
            cfg.width_m1  = '0;
            cfg.pad_bytes = 2'd1;
        end else begin
            cfg.width_m1  = width_reg[CountWidth-1:0] - CountWidth'(1);
            cfg.pad_bytes = width_reg[1:0];
        end
        if (height_reg[SizeWidth-1]) begin
            cfg.height_m1 = '1;
        end else if (height_reg == '0) begin
            cfg.height_m1 = '0;
        end else begin
            cfg.height_m1 = height_reg[CountWidth-1:0] - CountWidth'(1);
        end
        cfg.four_byte     = four_byte_reg;
        cfg.column_offset = col_off_reg;
        cfg.row_offset    = row_off_reg;
    end

endmodule

// File: hdl/bpsu_input_stage.sv
// Input register that holds one byte beat until the decoder takes it.
`include "assert_macros.svh"

module bpsu_input_stage
    import bpsu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ByteWidth-1:0] s_axis_tdata,
    output logic                 byte_valid,
    output logic [ByteWidth-1:0] byte_data,
    input  logic                 byte_take
);

    logic                 valid_reg;
    logic [ByteWidth-1:0] data_reg;

    assign s_axis_tready = !valid_reg || byte_take;
    assign byte_valid    = valid_reg;
    assign byte_data     = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            data_reg <= s_axis_tdata;
        end
    end

    `BPSU_ASSERT(a_take_needs_byte, aclk, aresetn, byte_take |-> valid_reg, "take without a held byte")

endmodule

// File: hdl/bpsu_decoder.sv
// Pixel assembly, row and column tracking, and the result register.
`include "assert_macros.svh"

module bpsu_decoder
    import bpsu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bpsu_cfg_t               cfg,
    input  logic                    byte_valid,
    input  logic [ByteWidth-1:0]    byte_data,
    output logic                    byte_take,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OutDataWidth-1:0] m_axis_tdata,
    output logic                    m_axis_tlast
);

    logic [CountWidth-1:0] col_reg, col_next;
    logic [CountWidth-1:0] line_reg, line_next;
    byte_phase_t           phase_reg, phase_next;
    logic [1:0]            pad_reg, pad_next;
    logic [ByteWidth-1:0]  blue_reg, blue_next;
    logic [ByteWidth-1:0]  green_reg, green_next;

    logic                    out_valid_reg;
    logic [OutDataWidth-1:0] out_data_reg;
    logic                    out_last_reg;

    logic                  emit;
    logic                  last_col;
    logic                  last_line;
    logic [SizeWidth-1:0]  row_sum;
    logic [SizeWidth-1:0]  col_sum;

    assign byte_take = byte_valid && (!out_valid_reg || m_axis_tready);

    assign last_col  = col_reg >= cfg.width_m1;
    assign last_line = line_reg >= cfg.height_m1;
    assign row_sum   = SizeWidth'(cfg.height_m1) - SizeWidth'(line_reg)
                     + SizeWidth'(cfg.row_offset);
    assign col_sum   = SizeWidth'(col_reg) + SizeWidth'(cfg.column_offset);

    always_comb begin
        col_next   = col_reg;
        line_next  = line_reg;
        phase_next = phase_reg;
        pad_next   = pad_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        emit       = 1'b0;
        if (pad_reg != 2'd0) begin
            pad_next = pad_reg - 2'd1;
        end else begin
            case (phase_reg)
                PHASE_BLUE: begin
                    blue_next  = byte_data;
                    phase_next = PHASE_GREEN;
                end
                PHASE_GREEN: begin
                    green_next = byte_data;
                    phase_next = PHASE_RED;
                end
                PHASE_RED: begin
                    emit       = 1'b1;
                    phase_next = cfg.four_byte ? PHASE_RESERVED : PHASE_BLUE;
                    if (last_col) begin
                        col_next  = '0;
                        line_next = last_line ? '0 : line_reg + CountWidth'(1);
                        if (!cfg.four_byte) begin
                            pad_next = cfg.pad_bytes;
                        end
                    end else begin
                        col_next = col_reg + CountWidth'(1);
                    end
                end
                PHASE_RESERVED: begin
                    phase_next = PHASE_BLUE;
                end
                default: begin
                    phase_next = PHASE_BLUE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            line_reg  <= '0;
            phase_reg <= PHASE_BLUE;
            pad_reg   <= '0;
            blue_reg  <= '0;
            green_reg <= '0;
        end else if (byte_take) begin
            col_reg   <= col_next;
            line_reg  <= line_next;
            phase_reg <= phase_next;
            pad_reg   <= pad_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (byte_take && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_take && emit) begin
            out_data_reg <= {byte_data, green_reg, blue_reg, col_sum, row_sum};
            out_last_reg <= last_col && last_line;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    `BPSU_ASSERT(a_pad_counts_down, aclk, aresetn, (byte_take && pad_reg != 2'd0) |=> (!$rose(out_valid_reg) && pad_reg == $past(pad_reg) - 2'd1), "padding beat did not count down")
    `BPSU_ASSERT(a_final_wraps, aclk, aresetn, (byte_take && emit && last_col && last_line) |=> (col_reg == '0 && line_reg == '0), "frame end did not clear the counters")
    `BPSU_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (!out_valid_reg && phase_reg == PHASE_BLUE && pad_reg == 2'd0), "reset left the decoder busy")

endmodule

// File: hdl/bmp_pixel_stream_unpacker.sv
// Top level of the BMP pixel stream unpacker.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tdata[7:0] pixel_byte
//   m_axis    out        tdata screen_row, screen_column, colour; tlast final_pixel
//   cfg       in         cfg_index selects the register, cfg_wdata is written
//
// One byte beat is taken every cycle unless a held result stalls the decoder.
// The rate is set by the single decode step between the input and result registers.
// Reset is synchronous and active low; it clears counters, phase and the valid flags of both registers.
// A held result that is not taken blocks the decoder, so the input stalls once the
// input register holds a byte.
module bmp_pixel_stream_unpacker
    import bpsu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [ByteWidth-1:0]    s_axis_tdata,    // [7:0] pixel_byte
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OutDataWidth-1:0] m_axis_tdata,    // [15:0] screen_row, [31:16] screen_column,
                                                     // [55:32] colour
    output logic                    m_axis_tlast,
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_wdata
);

    bpsu_cfg_t            cfg;
    logic                 byte_valid;
    logic [ByteWidth-1:0] byte_data;
    logic                 byte_take;

    bpsu_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bpsu_input_stage u_input_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data),
        .byte_take     (byte_take)
    );

    bpsu_decoder u_decoder (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data),
        .byte_take     (byte_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
